FILE: src/ecc_pkg.sv
package ecc_pkg;

  localparam int FLOORS   = 10;
  localparam int CAPACITY = 16;
  localparam int WAIT_MAX = 15;

  localparam int OP_W      = 3;
  localparam int FLOOR_W   = 4;
  localparam int POS_W     = 14;
  localparam int RIDER_W   = 5;
  localparam int WAIT_W    = 4;
  localparam int FH_W      = 10;
  localparam int SPEED_W   = 8;
  localparam int DWELL_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  localparam logic [FH_W-1:0]    FH_RESET    = FH_W'(64);
  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(2);
  localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(120);

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CALL_UP = 3'd1,
    OP_CALL_DN = 3'd2,
    OP_DEST    = 3'd3,
    OP_EVAC    = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR_HEIGHT = 2'd0,
    CFG_SPEED        = 2'd1,
    CFG_DWELL_TICKS  = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [FLOOR_W-1:0] floor_now;
    logic               is_moving;
    logic               heading_up;
    logic [FLOORS-1:0]  targets;
    logic [FLOORS-1:0]  up_lamps;
    logic [FLOORS-1:0]  down_lamps;
    logic [RIDER_W-1:0] riders;
    logic [DWELL_W-1:0] dwell_left;
    logic               overflow;
  } res_t;

  function automatic logic [FLOOR_W-1:0] next_tgt(logic [FLOORS-1:0] set, logic up);
    logic [FLOOR_W-1:0] r;
    r = '0;
    if (up) begin
      for (int i = FLOORS - 1; i >= 0; i--) begin
        if (set[i]) r = FLOOR_W'(i);
      end
    end else begin
      for (int i = 0; i < FLOORS; i++) begin
        if (set[i]) r = FLOOR_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [FLOORS-1:0] flr_bit(logic [FLOOR_W-1:0] f);
    return FLOORS'(1) << f;
  endfunction

endpackage

FILE: src/elevator_call_controller.sv
// Single-car elevator call controller.
// Input channel (in_valid_i / in_ready_o) carries one transaction per event:
// op_i selects tick, up or down hall call, cabin destination key or evacuate
// key; floor_i names the floor for calls and destination keys.
// Output channel (out_valid_o / out_ready_i) returns one result transaction
// per input transaction, in order, showing car state after that event.
// Configuration: cfg_we_i writes cfg_wdata_i into floor height (index 0),
// speed (index 1) or dwell ticks (index 2); write only while idle.
// Path: a transaction accepted into the input register is presented as a result
// from the result register (input register, then result register).
// Throughput: one transaction per cycle while results are taken, set by the
// combinational state update between the input register and the result register.
// Reset: car state, call counts and rider counts clear, heading is up,
// configuration returns to 64 / 2 / 120, both channels empty.
// Stall: a result not taken holds; one more transaction is still accepted
// into the input register, after which in_ready_o drops until space frees.
module elevator_call_controller import ecc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [FLOOR_W-1:0]   floor_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [POS_W-1:0]     position_o,
  output logic [FLOOR_W-1:0]   floor_now_o,
  output logic                 is_moving_o,
  output logic                 heading_up_o,
  output logic [FLOORS-1:0]    targets_o,
  output logic [FLOORS-1:0]    up_lamps_o,
  output logic [FLOORS-1:0]    down_lamps_o,
  output logic [RIDER_W-1:0]   riders_o,
  output logic [DWELL_W-1:0]   dwell_left_o,
  output logic                 overflow_o
);

  logic               s1_valid_q;
  logic [OP_W-1:0]    s1_op_q;
  logic [FLOOR_W-1:0] s1_floor_q;
  logic               out_free;
  logic               fire;
  res_t               core_res;
  res_t               out_res;

  assign fire       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q    <= op_i;
      s1_floor_q <= floor_i;
    end
  end

  ecc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .op_i        (s1_op_q),
    .floor_i     (s1_floor_q),
    .res_o       (core_res)
  );

  ecc_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (core_res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign position_o   = out_res.position;
  assign floor_now_o  = out_res.floor_now;
  assign is_moving_o  = out_res.is_moving;
  assign heading_up_o = out_res.heading_up;
  assign targets_o    = out_res.targets;
  assign up_lamps_o   = out_res.up_lamps;
  assign down_lamps_o = out_res.down_lamps;
  assign riders_o     = out_res.riders;
  assign dwell_left_o = out_res.dwell_left;
  assign overflow_o   = out_res.overflow;

endmodule

FILE: src/ecc_core.sv
module ecc_core import ecc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 fire_i,
  input  logic [OP_W-1:0]      op_i,
  input  logic [FLOOR_W-1:0]   floor_i,
  output res_t                 res_o
);

  logic [FH_W-1:0]    fh_q;
  logic [SPEED_W-1:0] speed_q;
  logic [DWELL_W-1:0] dwell_ticks_q;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [FLOOR_W-1:0] last_q, last_d;
  logic               active_q, active_d;
  logic               up_q, up_d;
  logic [DWELL_W-1:0] dwell_q, dwell_d;
  logic [FLOORS-1:0]  tset_q, tset_d;
  logic [FLOORS-1:0]  ucf_q, ucf_d;
  logic [FLOORS-1:0]  dcf_q, dcf_d;
  logic [WAIT_W-1:0]  wup_q [FLOORS];
  logic [WAIT_W-1:0]  wup_d [FLOORS];
  logic [WAIT_W-1:0]  wdn_q [FLOORS];
  logic [WAIT_W-1:0]  wdn_d [FLOORS];
  logic [RIDER_W-1:0] bound_q [FLOORS];
  logic [RIDER_W-1:0] bound_d [FLOORS];
  logic [RIDER_W-1:0] unas_q, unas_d;
  logic [RIDER_W-1:0] evac_q, evac_d;
  logic [RIDER_W-1:0] total_q, total_d;
  logic               ovf;

  op_e                op;
  logic [FLOOR_W-1:0] tf;
  logic [POS_W-1:0]   tp;
  logic [POS_W:0]     np;
  logic               arrive;
  logic [FLOOR_W-1:0] sel;
  logic               sel_ok;
  logic [WAIT_W-1:0]  wup_sel, wdn_sel, wq;
  logic [RIDER_W-1:0] bound_sel;
  logic [RIDER_W-1:0] rem, room, nb;

  assign op        = op_e'(op_i);
  assign tf        = next_tgt(tset_q, up_q);
  assign tp        = POS_W'(tf) * POS_W'(fh_q);
  assign np        = {1'b0, pos_q} + (POS_W+1)'(speed_q);
  assign arrive    = up_q ? (np >= {1'b0, tp})
                          : ((pos_q < POS_W'(speed_q)) || (pos_q - POS_W'(speed_q) <= tp));
  assign sel       = (op == OP_TICK) ? tf : floor_i;
  assign sel_ok    = (sel < FLOOR_W'(FLOORS));
  assign wup_sel   = sel_ok ? wup_q[sel] : '0;
  assign wdn_sel   = sel_ok ? wdn_q[sel] : '0;
  assign bound_sel = sel_ok ? bound_q[sel] : '0;

  assign rem  = total_q - bound_sel - evac_q;
  assign room = RIDER_W'(CAPACITY) - rem;
  assign wq   = up_q ? wup_sel : wdn_sel;
  assign nb   = (RIDER_W'(wq) > room) ? room : RIDER_W'(wq);

  always_comb begin
    pos_d    = pos_q;
    last_d   = last_q;
    active_d = active_q;
    up_d     = up_q;
    dwell_d  = dwell_q;
    tset_d   = tset_q;
    ucf_d    = ucf_q;
    dcf_d    = dcf_q;
    wup_d    = wup_q;
    wdn_d    = wdn_q;
    bound_d  = bound_q;
    unas_d   = unas_q;
    evac_d   = evac_q;
    total_d  = total_q;
    ovf      = 1'b0;

    unique case (op)
      OP_TICK: begin
        if (!active_q || dwell_q != '0) begin
          if (dwell_q != '0) dwell_d = dwell_q - DWELL_W'(1);
        end else if (tset_q == '0) begin
          active_d = 1'b0;
        end else if (arrive) begin
          pos_d       = tp;
          last_d      = tf;
          bound_d[tf] = '0;
          evac_d      = '0;
          ovf         = (RIDER_W'(wq) > room);
          unas_d      = unas_q + nb;
          total_d     = rem + nb;
          if (up_q) begin
            wup_d[tf] = '0;
            ucf_d     = ucf_q & ~flr_bit(tf);
          end else begin
            wdn_d[tf] = '0;
            dcf_d     = dcf_q & ~flr_bit(tf);
          end
          tset_d = tset_q & ~flr_bit(tf);
          if (tset_d == '0) begin
            active_d = 1'b0;
          end else begin
            up_d = (next_tgt(tset_d, up_q) > tf);
          end
          dwell_d = dwell_ticks_q;
          if (tf == '0) begin
            unas_d  = '0;
            total_d = '0;
            for (int i = 0; i < FLOORS; i++) begin
              bound_d[i] = '0;
            end
          end
        end else if (up_q) begin
          pos_d = np[POS_W-1:0];
        end else begin
          pos_d = pos_q - POS_W'(speed_q);
        end
      end
      OP_CALL_UP, OP_CALL_DN: begin
        if (sel_ok) begin
          if (op == OP_CALL_UP) begin
            if (wup_sel >= WAIT_W'(WAIT_MAX)) begin
              wup_d[sel] = WAIT_W'(WAIT_MAX);
              ovf        = 1'b1;
            end else begin
              wup_d[sel] = wup_sel + WAIT_W'(1);
            end
            ucf_d = ucf_q | flr_bit(sel);
          end else begin
            if (wdn_sel >= WAIT_W'(WAIT_MAX)) begin
              wdn_d[sel] = WAIT_W'(WAIT_MAX);
              ovf        = 1'b1;
            end else begin
              wdn_d[sel] = wdn_sel + WAIT_W'(1);
            end
            dcf_d = dcf_q | flr_bit(sel);
          end
          tset_d   = tset_q | flr_bit(sel);
          up_d     = (next_tgt(tset_d, up_q) > last_q);
          active_d = 1'b1;
        end
      end
      OP_DEST: begin
        if (sel_ok && unas_q != '0) begin
          bound_d[sel] = bound_sel + unas_q;
          unas_d       = '0;
          tset_d       = tset_q | flr_bit(sel);
          up_d         = (next_tgt(tset_d, up_q) > last_q);
          active_d     = 1'b1;
        end
      end
      OP_EVAC: begin
        evac_d = total_q;
        unas_d = '0;
        for (int i = 0; i < FLOORS; i++) begin
          bound_d[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q          <= FH_RESET;
      speed_q       <= SPEED_RESET;
      dwell_ticks_q <= DWELL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_FLOOR_HEIGHT: fh_q          <= cfg_wdata_i[FH_W-1:0];
        CFG_SPEED:        speed_q       <= cfg_wdata_i[SPEED_W-1:0];
        CFG_DWELL_TICKS:  dwell_ticks_q <= cfg_wdata_i[DWELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      last_q   <= '0;
      active_q <= 1'b0;
      up_q     <= 1'b1;
      dwell_q  <= '0;
      tset_q   <= '0;
      ucf_q    <= '0;
      dcf_q    <= '0;
      unas_q   <= '0;
      evac_q   <= '0;
      total_q  <= '0;
      for (int i = 0; i < FLOORS; i++) begin
        wup_q[i]   <= '0;
        wdn_q[i]   <= '0;
        bound_q[i] <= '0;
      end
    end else if (fire_i) begin
      pos_q    <= pos_d;
      last_q   <= last_d;
      active_q <= active_d;
      up_q     <= up_d;
      dwell_q  <= dwell_d;
      tset_q   <= tset_d;
      ucf_q    <= ucf_d;
      dcf_q    <= dcf_d;
      unas_q   <= unas_d;
      evac_q   <= evac_d;
      total_q  <= total_d;
      wup_q    <= wup_d;
      wdn_q    <= wdn_d;
      bound_q  <= bound_d;
    end
  end

  always_comb begin
    res_o.position   = pos_d;
    res_o.floor_now  = last_d;
    res_o.is_moving  = active_d;
    res_o.heading_up = up_d;
    res_o.targets    = tset_d;
    res_o.up_lamps   = ucf_d;
    res_o.down_lamps = dcf_d;
    res_o.riders     = total_d;
    res_o.dwell_left = dwell_d;
    res_o.overflow   = ovf;
  end

endmodule

FILE: src/ecc_out_reg.sv
module ecc_out_reg import ecc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
